@@ rtl/core/sorted_priority_queue_defines.svh @@
// Assertion macros for the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/spq_pkg.sv @@
package spq_pkg;

   localparam int VALUE_W  = 32;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_FIND   = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic                      ins;
      logic                      del;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic                      occ;
      logic                      lt;
      logic                      eq;
      logic signed [VALUE_W-1:0] value;
      logic                      next_occ;
      logic signed [VALUE_W-1:0] next_value;
   } cell_view_type;

endpackage

@@ rtl/core/sorted_priority_queue.sv @@
// Sorted priority queue of signed 32-bit values, ascending, up to CAPACITY entries.
// Request channel (req_valid, req_stall, req_type, req_item_value): insert, remove
// the first equal entry, or find the first equal entry.
// Response channel (rsp_valid, rsp_stall, rsp_*): one transaction per request with
// status, rank of the affected entry, head value, head valid flag and entry count.
// Every entry sits in its own cell; all cells compare against the request value in
// parallel and shift toward their neighbors in the same cycle, so a request takes
// effect at the edge that accepts it.
// The response is registered: it is valid in the cycle after acceptance.
// Throughput is one request per cycle, set by the single compare-and-shift step of
// the cell row, as long as the response register drains.
// When the receiver stalls, the response register holds and req_stall rises until
// the held transaction is taken.
// Reset empties the queue and drops any pending response; the block accepts
// requests right after it.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic signed [spq_pkg::VALUE_W-1:0] req_item_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [spq_pkg::POS_W-1:0]         rsp_position,
   output logic signed [spq_pkg::VALUE_W-1:0] rsp_head_value,
   output logic                              rsp_head_valid,
   output logic [spq_pkg::COUNT_W-1:0]       rsp_entry_count
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   cell_cmd_type              cmd;
   cell_view_type             views [CAPACITY];
   cell_view_type             left_edge;
   cell_view_type             right_edge;
   logic [CAPACITY-1:0]       occ_vec;
   logic [CAPACITY-1:0]       edge_vec;
   logic [CW-1:0]             rank;
   logic                      found;
   logic                      full;
   logic                      accept;

   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [1:0]                status_ff;
   logic [1:0]                status_in;
   logic [POS_W-1:0]          position_ff;
   logic [POS_W-1:0]          position_in;
   logic signed [VALUE_W-1:0] head_value_ff;
   logic signed [VALUE_W-1:0] head_value_in;
   logic                      head_valid_ff;
   logic                      head_valid_in;
   logic [COUNT_W-1:0]        entry_count_ff;
   logic [COUNT_W-1:0]        entry_count_in;
   logic [CW+POS_W-1:0]       rank_ext;
   logic [CW+COUNT_W-1:0]     count_ext;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(CAPACITY));

   assign left_edge  = '{occ: 1'b0, lt: 1'b1, eq: 1'b0, value: '0,
                         next_occ: 1'b0, next_value: '0};
   assign right_edge = '{occ: 1'b0, lt: 1'b0, eq: 1'b0, value: '0,
                         next_occ: 1'b0, next_value: '0};

   assign cmd.value = req_item_value;
   assign cmd.ins   = accept && (req_type == REQ_INSERT) && !full;
   assign cmd.del   = accept && (req_type == REQ_REMOVE) && found;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_view_type left_view;
      cell_view_type right_view;
      if (i == 0) begin : g_first
         assign left_view = left_edge;
      end else begin : g_mid_left
         assign left_view = views[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_view = right_edge;
      end else begin : g_mid_right
         assign right_view = views[i+1];
      end
      spq_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .left  (left_view),
         .right (right_view),
         .view  (views[i])
      );
      assign occ_vec[i]  = views[i].occ;
      assign edge_vec[i] = left_view.lt && !views[i].lt;
   end

   always_comb begin
      rank  = '0;
      found = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         rank  = rank | (edge_vec[i] ? CW'(i) : '0);
         found = found | (edge_vec[i] && views[i].eq);
      end
   end

   always_comb begin
      rank_ext    = {{POS_W{1'b0}}, rank};
      status_in   = ST_MISS;
      position_in = '0;
      count_in    = count_ff;
      unique case (req_type)
         REQ_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in   = ST_DONE;
               position_in = rank_ext[POS_W-1:0];
               count_in    = count_ff + 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (found) begin
               status_in   = ST_DONE;
               position_in = rank_ext[POS_W-1:0];
               count_in    = count_ff - 1'b1;
            end
         end
         REQ_FIND: begin
            if (found) begin
               status_in   = ST_DONE;
               position_in = rank_ext[POS_W-1:0];
            end
         end
         default: begin
            status_in = ST_MISS;
         end
      endcase
      count_ext      = {{COUNT_W{1'b0}}, count_in};
      entry_count_in = count_ext[COUNT_W-1:0];
      head_valid_in  = views[0].next_occ;
      head_value_in  = views[0].next_occ ? views[0].next_value : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         position_ff    <= position_in;
         head_value_ff  <= head_value_in;
         head_valid_ff  <= head_valid_in;
         entry_count_ff <= entry_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_position    = position_ff;
   assign rsp_head_value  = head_value_ff;
   assign rsp_head_valid  = head_valid_ff;
   assign rsp_entry_count = entry_count_ff;

   `SPQ_ASSERT_NOW(a_occ_matches_count, clock, reset, 1'b1,
      $countones(occ_vec) == int'(count_ff), "Cell occupancy disagrees with the entry count.")
   `SPQ_ASSERT_NOW(a_head_valid_count, clock, reset, rsp_valid_ff,
      rsp_head_valid == (count_ff != '0), "Head valid flag disagrees with the entry count.")
   `SPQ_ASSERT_NEXT(a_remove_shrinks, clock, reset, cmd.del,
      count_ff == $past(count_ff) - 1'b1, "A successful remove did not drop the count by one.")
   `SPQ_ASSERT_NOW(a_one_edge, clock, reset, !full,
      $onehot(edge_vec), "Rank boundary across the cell row is not unique.")

endmodule

@@ rtl/core/spq_cell.sv @@
module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::cell_cmd_type  cmd,
   input  spq_pkg::cell_view_type left,
   input  spq_pkg::cell_view_type right,
   output spq_pkg::cell_view_type view
);
   import spq_pkg::*;

   logic                      occ_ff;
   logic                      occ_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      lt;
   logic                      eq;

   assign lt = occ_ff && (value_ff < cmd.value);
   assign eq = occ_ff && (value_ff == cmd.value);

   // Entries at or after the insert point shift right; at or after a removed one, left.
   always_comb begin
      occ_in   = occ_ff;
      value_in = value_ff;
      priority if (cmd.ins && !lt) begin
         if (left.lt) begin
            occ_in   = 1'b1;
            value_in = cmd.value;
         end else begin
            occ_in   = left.occ;
            value_in = left.value;
         end
      end else if (cmd.del && !lt) begin
         occ_in   = right.occ;
         value_in = right.value;
      end else begin
         occ_in   = occ_ff;
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign view.occ        = occ_ff;
   assign view.lt         = lt;
   assign view.eq         = eq;
   assign view.value      = value_ff;
   assign view.next_occ   = occ_in;
   assign view.next_value = value_in;

endmodule

@@ dv/sorted_priority_queue_test.sv @@
`timescale 1ns / 100ps

module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam int CAPACITY = 16;
   localparam logic [1:0] REQ_UNDEFINED = 2'd3;
   localparam logic signed [VALUE_W-1:0] MIN_VALUE = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;
   localparam int RANDOM_ITEMS = 820;
   localparam int LONG_HOLD_AT = 12;
   localparam int LONG_HOLD_CYCLES = 80;

   typedef struct {
      logic [1:0]                kind;
      logic signed [VALUE_W-1:0] value;
      int unsigned               gap;
      bit                        drain_first;
   } queue_request_type;

   typedef struct {
      logic [1:0]                status;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] head_value;
      logic                      head_valid;
      logic [COUNT_W-1:0]        entry_count;
   } queue_reply_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_type = REQ_INSERT;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_status;
   logic [POS_W-1:0]          rsp_position;
   logic signed [VALUE_W-1:0] rsp_head_value;
   logic                      rsp_head_valid;
   logic [COUNT_W-1:0]        rsp_entry_count;

   queue_request_type request_backlog[$];
   queue_reply_type   expected_replies[$];

   logic signed [VALUE_W-1:0] model_entries[CAPACITY];
   int model_count = 0;

   int sent_total = 0;
   int taken_total = 0;
   int replies_seen = 0;
   int error_count = 0;
   int unsigned gap_done = 0;
   int hold_left = 0;
   bit stall_busy = 1'b1;

   sorted_priority_queue #(.CAPACITY(CAPACITY)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_head_value  (rsp_head_value),
      .rsp_head_valid  (rsp_head_valid),
      .rsp_entry_count (rsp_entry_count)
   );

   always #5 clock = ~clock;

   function automatic queue_reply_type apply_to_model(input logic [1:0] kind,
                                                      input logic signed [VALUE_W-1:0] value);
      queue_reply_type reply;
      int rank;
      int i;
      reply.status = ST_MISS;
      reply.position = '0;
      rank = 0;
      while (rank < model_count && model_entries[rank] < value) rank++;
      if (kind == REQ_INSERT) begin
         if (model_count >= CAPACITY) begin
            reply.status = ST_FULL;
         end else begin
            for (i = model_count; i > rank; i--) model_entries[i] = model_entries[i-1];
            model_entries[rank] = value;
            model_count++;
            reply.status = ST_DONE;
            reply.position = rank[POS_W-1:0];
         end
      end else if (kind == REQ_REMOVE || kind == REQ_FIND) begin
         if (rank < model_count && model_entries[rank] == value) begin
            reply.status = ST_DONE;
            reply.position = rank[POS_W-1:0];
            if (kind == REQ_REMOVE) begin
               for (i = rank; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
               model_count--;
            end
         end
      end
      reply.head_value = (model_count != 0) ? model_entries[0] : '0;
      reply.head_valid = (model_count != 0);
      reply.entry_count = model_count[COUNT_W-1:0];
      return reply;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("reply %0d: %s is %h, predicted %h", replies_seen, what, got, want);
      error_count++;
   endtask

   task automatic add_request(input logic [1:0] kind, input logic signed [VALUE_W-1:0] value,
                              input int unsigned gap, input bit drain_first);
      queue_request_type item;
      item.kind = kind;
      item.value = value;
      item.gap = gap;
      item.drain_first = drain_first;
      request_backlog.push_back(item);
   endtask

   // Driver: the payload is held while the block stalls the request channel.
   always @(posedge clock) begin
      queue_request_type next_req;
      bit accepted;
      if (reset) begin
         req_valid <= 1'b0;
         gap_done = 0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            expected_replies.push_back(apply_to_model(req_type, req_item_value));
            sent_total <= sent_total + 1;
         end
         if (req_valid && !accepted) begin
            req_valid <= 1'b1;
         end else if (request_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            next_req = request_backlog[0];
            if (next_req.drain_first && (sent_total + int'(accepted) != taken_total)) begin
               req_valid <= 1'b0;
            end else if (gap_done < next_req.gap) begin
               gap_done++;
               req_valid <= 1'b0;
            end else begin
               void'(request_backlog.pop_front());
               gap_done = 0;
               req_valid <= 1'b1;
               req_type <= next_req.kind;
               req_item_value <= next_req.value;
            end
         end
      end
   end

   // Monitor: checks each response transaction and draws the stall for the next one.
   always @(posedge clock) begin
      queue_reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            taken_total <= taken_total + 1;
            replies_seen++;
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected response, status", rsp_status, '0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_position !== want.position)
                  report_mismatch("position", rsp_position, want.position);
               if (rsp_head_value !== want.head_value)
                  report_mismatch("head_value", rsp_head_value, want.head_value);
               if (rsp_head_valid !== want.head_valid)
                  report_mismatch("head_valid", rsp_head_valid, want.head_valid);
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch("entry_count", rsp_entry_count, want.entry_count);
            end
            if (replies_seen == LONG_HOLD_AT) begin
               hold_left = LONG_HOLD_CYCLES;
            end else begin
               if (replies_seen % 64 == 0) stall_busy = $urandom_range(0, 1);
               hold_left = stall_busy ? $urandom_range(0, 16) : 0;
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic signed [VALUE_W-1:0] pool[8];
      logic signed [VALUE_W-1:0] value;
      logic [1:0] kind;
      int produced;
      int phase;
      int phase_len;
      int insert_pct;
      int r;
      int i;
      bit busy;

      // The directed sequence runs back to back so that the long receiver hold backs up requests at the block.
      add_request(REQ_FIND, 32'sd5, 0, 1'b0);
      add_request(REQ_REMOVE, 32'sd5, 0, 1'b0);
      add_request(REQ_UNDEFINED, 32'sd0, 0, 1'b0);
      add_request(REQ_INSERT, 32'sd0, 0, 1'b0);
      add_request(REQ_INSERT, MAX_VALUE, 0, 1'b0);
      add_request(REQ_INSERT, MIN_VALUE, 0, 1'b0);
      add_request(REQ_INSERT, -32'sd1, 0, 1'b0);
      add_request(REQ_INSERT, 32'sd0, 0, 1'b0);
      add_request(REQ_FIND, MAX_VALUE, 0, 1'b0);
      add_request(REQ_FIND, 32'sd5, 0, 1'b0);
      add_request(REQ_REMOVE, -32'sd1, 0, 1'b0);
      add_request(REQ_REMOVE, MIN_VALUE, 0, 1'b0);
      add_request(REQ_UNDEFINED, MAX_VALUE, 0, 1'b0);
      for (i = 0; i < 13; i++) add_request(REQ_INSERT, $urandom, 0, 1'b0);
      add_request(REQ_INSERT, 32'sd7, 0, 1'b0);
      add_request(REQ_FIND, MAX_VALUE, 0, 1'b0);
      add_request(REQ_REMOVE, MAX_VALUE, 0, 1'b0);

      // Random phases shift the balance between inserts and removals so that the
      // queue swings between empty and full, with values drawn mostly from a small pool.
      produced = 0;
      phase = 0;
      while (produced < RANDOM_ITEMS) begin
         phase_len = $urandom_range(10, 40);
         case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 50;
            default: insert_pct = 20;
         endcase
         busy = $urandom_range(0, 2) != 0;
         pool[0] = MIN_VALUE;
         pool[1] = MAX_VALUE;
         pool[2] = 32'sd0;
         pool[3] = -32'sd1;
         for (i = 4; i < 8; i++) pool[i] = ($urandom_range(0, 1) != 0) ? $urandom
                                                      : $signed($urandom_range(0, 20)) - 10;
         for (i = 0; i < phase_len && produced < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 3) kind = REQ_UNDEFINED;
            else if (r < insert_pct) kind = REQ_INSERT;
            else if (r < insert_pct + (100 - insert_pct) / 2) kind = REQ_REMOVE;
            else kind = REQ_FIND;
            value = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, 7)] : $urandom;
            add_request(kind, value, busy ? $urandom_range(0, 16) : 0,
                        i == 0 && phase % 5 == 0);
            produced++;
         end
         phase++;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || sent_total != taken_total);
      repeat (8) @(posedge clock);
      if (expected_replies.size() != 0)
         report_mismatch("responses missing at end, count", expected_replies.size(), 0);
      if (error_count == 0) begin
         $display("sorted_priority_queue_test: clean");
      end else begin
         $display("sorted_priority_queue_test: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("sorted_priority_queue_test: errors");
      $finish;
   end

endmodule
